FILE: rtl/lepl_pkg.sv
package lepl_pkg;

  localparam logic [1:0] OP_LOAD = 2'd0;
  localparam logic [1:0] OP_SIM  = 2'd1;
  localparam logic [1:0] OP_EVAL = 2'd2;

  localparam logic [0:0] CFG_POINT_COUNT = 1'd0;
  localparam logic [0:0] CFG_ONLY_SCALE  = 1'd1;

  localparam logic [31:0] LN2_Q32    = 32'd2977044472;
  localparam logic [27:0] LN1000_Q16 = 28'd452707;
  localparam int          SQR_STEPS  = 20;
  localparam int          DIV_STEPS  = 58;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [3:0]         point_index;
    logic signed [27:0] point_log_energy;
    logic signed [27:0] point_response;
    logic [39:0]        kinetic_energy_kev;
    logic [39:0]        current_energy_kev;
  } in_t;

  typedef struct packed {
    logic signed [40:0] mean_energy_kev;
    logic signed [27:0] response_value;
  } out_t;

  typedef enum logic [4:0] {
    CMD_NONE,
    CMD_WRITE,
    CMD_CAPTURE,
    CMD_NORM,
    CMD_SQR_INIT,
    CMD_SQR,
    CMD_LNMUL,
    CMD_LNFIN,
    CMD_CAP_LO,
    CMD_CAP_HI,
    CMD_SRCH_RD,
    CMD_SRCH_CMP,
    CMD_SEL,
    CMD_RD_S0,
    CMD_CAP_S0,
    CMD_CAP_S1,
    CMD_DIFF,
    CMD_Y0,
    CMD_MUL,
    CMD_DIV_INIT,
    CMD_DIV,
    CMD_DIV_FIN,
    CMD_SAT,
    CMD_SCALE,
    CMD_FIN
  } cmd_e;

  typedef struct packed {
    logic norm_done;
    logic sqr_last;
    logic srch_more;
    logic below;
    logic above;
    logic is_sim;
    logic dx_le0;
    logic div_last;
    logic out_busy;
  } dp_status_t;

endpackage

FILE: rtl/log_energy_piecewise_linear_response_core.sv
// Piecewise-linear response over ln(E/MeV) with a breakpoint table of up to
// MAX_POINTS entries. A load transaction writes one breakpoint. A simulate or
// evaluate transaction runs one item at a time through a shared datapath:
// leading-one search on the energy (one bit a cycle), 20 squaring steps for
// the log2 fraction, a linear scan of the table (one table read port), and a
// restoring divider for the segment slope. The next item is taken only once
// the core is back in idle. Results wait in an output register, so the next
// item is taken while the previous result is still stalled.
module log_energy_piecewise_linear_response_core import lepl_pkg::*; #(
  parameter int MAX_POINTS = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  in_t        in_data_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output out_t       out_data_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] cfg_index_i,
  input  logic [4:0] cfg_data_i
);

  logic [4:0] point_count_q;
  logic       only_scale_q;
  cmd_e       cmd;
  dp_status_t status;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      point_count_q <= 5'd2;
      only_scale_q  <= 1'b0;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == 2'(CFG_POINT_COUNT)) point_count_q <= cfg_data_i;
      if (cfg_index_i == 2'(CFG_ONLY_SCALE))  only_scale_q  <= cfg_data_i[0];
    end
  end

  lepl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .opcode_i   (in_data_i.opcode),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  lepl_dp #(.MaxPoints(MAX_POINTS)) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .in_data_i     (in_data_i),
    .point_count_i (point_count_q),
    .only_scale_i  (only_scale_q),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_data_o    (out_data_o)
  );

`ifndef SYNTHESIS
  a_work_blocks_input : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o &&
     (in_data_i.opcode == OP_SIM || in_data_i.opcode == OP_EVAL)) |=> in_stall_o)
    else $error("input not blocked after a compute transaction");
  a_load_single_cycle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && in_data_i.opcode == OP_LOAD) |=> !in_stall_o)
    else $error("load transaction held the input");
  a_result_from_work : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared without work in progress");
`endif

endmodule

FILE: rtl/lepl_ram.sv
module lepl_ram import lepl_pkg::*; #(
  parameter int Width = 56,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

FILE: rtl/lepl_ctrl.sv
module lepl_ctrl import lepl_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [1:0] opcode_i,
  output logic       in_stall_o,
  input  dp_status_t status_i,
  output cmd_e       cmd_o
);

  typedef enum logic [4:0] {
    S_IDLE, S_NORM, S_SQR, S_LNMUL, S_LNFIN, S_LO, S_HI, S_SRD, S_SCMP, S_SEL,
    S_RS0, S_RS1, S_RS2, S_DIFF, S_MUL, S_DIVI, S_DIV, S_DIVF, S_SAT, S_SCALE, S_FIN
  } state_e;

  state_e state_q, state_d;

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = CMD_NONE;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (opcode_i == OP_LOAD) begin
            cmd_o = CMD_WRITE;
          end else if (opcode_i == OP_SIM || opcode_i == OP_EVAL) begin
            cmd_o   = CMD_CAPTURE;
            state_d = S_NORM;
          end
        end
      end
      S_NORM: begin
        if (status_i.norm_done) begin
          cmd_o   = CMD_SQR_INIT;
          state_d = S_SQR;
        end else begin
          cmd_o = CMD_NORM;
        end
      end
      S_SQR: begin
        cmd_o = CMD_SQR;
        if (status_i.sqr_last) state_d = S_LNMUL;
      end
      S_LNMUL: begin
        cmd_o   = CMD_LNMUL;
        state_d = S_LNFIN;
      end
      S_LNFIN: begin
        cmd_o   = CMD_LNFIN;
        state_d = S_LO;
      end
      S_LO: begin
        cmd_o   = CMD_CAP_LO;
        state_d = S_HI;
      end
      S_HI: begin
        cmd_o   = CMD_CAP_HI;
        state_d = S_SRD;
      end
      S_SRD: begin
        if (status_i.srch_more) begin
          cmd_o   = CMD_SRCH_RD;
          state_d = S_SCMP;
        end else begin
          state_d = S_SEL;
        end
      end
      S_SCMP: begin
        cmd_o   = CMD_SRCH_CMP;
        state_d = S_SRD;
      end
      S_SEL: begin
        cmd_o = CMD_SEL;
        if (status_i.below || (status_i.above && !status_i.is_sim)) begin
          state_d = S_SAT;
        end else begin
          state_d = S_RS0;
        end
      end
      S_RS0: begin
        cmd_o   = CMD_RD_S0;
        state_d = S_RS1;
      end
      S_RS1: begin
        cmd_o   = CMD_CAP_S0;
        state_d = S_RS2;
      end
      S_RS2: begin
        cmd_o   = CMD_CAP_S1;
        state_d = S_DIFF;
      end
      S_DIFF: begin
        cmd_o   = CMD_DIFF;
        state_d = S_MUL;
      end
      S_MUL: begin
        if (status_i.dx_le0) begin
          cmd_o   = CMD_Y0;
          state_d = S_SAT;
        end else begin
          cmd_o   = CMD_MUL;
          state_d = S_DIVI;
        end
      end
      S_DIVI: begin
        cmd_o   = CMD_DIV_INIT;
        state_d = S_DIV;
      end
      S_DIV: begin
        cmd_o = CMD_DIV;
        if (status_i.div_last) state_d = S_DIVF;
      end
      S_DIVF: begin
        cmd_o   = CMD_DIV_FIN;
        state_d = S_SAT;
      end
      S_SAT: begin
        cmd_o   = CMD_SAT;
        state_d = status_i.is_sim ? S_SCALE : S_FIN;
      end
      S_SCALE: begin
        cmd_o   = CMD_SCALE;
        state_d = S_FIN;
      end
      S_FIN: begin
        // hold until the output register can take the result
        if (!status_i.out_busy) begin
          cmd_o   = CMD_FIN;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: rtl/lepl_dp.sv
module lepl_dp import lepl_pkg::*; #(
  parameter int MaxPoints = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cmd_e       cmd_i,
  output dp_status_t status_o,
  input  in_t        in_data_i,
  input  logic [4:0] point_count_i,
  input  logic       only_scale_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output out_t       out_data_o
);

  localparam int AW = (MaxPoints > 1) ? $clog2(MaxPoints) : 1;

  function automatic logic signed [27:0] sat28(input logic signed [59:0] v);
    if (v > 60'sd134217727) return 28'sd134217727;
    if (v < -60'sd134217728) return -28'sd134217728;
    return v[27:0];
  endfunction

  logic [1:0]         op_q;
  logic [39:0]        e_q, ke_q, ce_q;
  logic [5:0]         k_q;
  logic [30:0]        z_q;
  logic [19:0]        frac_q;
  logic [5:0]         cnt_q;
  logic [57:0]        p_q;
  logic signed [27:0] x_q, xlo_q, ylo_q, xhi_q, yhi_q, x0_q, y0_q, x1_q, y1_q, ys_q;
  logic [AW-1:0]      nm1_q, j_q, i_q, seg_q;
  logic signed [28:0] dx_q, dy_q, xd_q;
  logic signed [57:0] num_q;
  logic               neg_q;
  logic [57:0]        quo_q;
  logic [28:0]        rem_q;
  logic signed [59:0] y_q;
  logic [47:0]        a_q, b_q;
  logic               out_valid_q;
  out_t               out_q;

  logic [AW-1:0]      raddr;
  logic [55:0]        rdata;
  logic signed [27:0] rd_x, rd_y;
  logic               we;

  assign rd_x = rdata[55:28];
  assign rd_y = rdata[27:0];
  assign we   = (cmd_i == CMD_WRITE) && (32'(in_data_i.point_index) < 32'(MaxPoints));

  always_comb begin
    case (cmd_i)
      CMD_CAP_LO:  raddr = nm1_q;
      CMD_SRCH_RD: raddr = j_q;
      CMD_RD_S0:   raddr = seg_q;
      CMD_CAP_S0:  raddr = AW'(seg_q + 1'b1);
      default:     raddr = '0;
    endcase
  end

  lepl_ram #(.Width(56), .Depth(MaxPoints)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (AW'(in_data_i.point_index)),
    .wdata_i ({in_data_i.point_log_energy, in_data_i.point_response}),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_comb begin
    status_o.norm_done = e_q[39];
    status_o.sqr_last  = (cnt_q == 6'(SQR_STEPS - 1));
    status_o.srch_more = (j_q < nm1_q);
    status_o.below     = (x_q < xlo_q);
    status_o.above     = (x_q > xhi_q);
    status_o.is_sim    = (op_q == OP_SIM);
    status_o.dx_le0    = (dx_q <= 29'sd0);
    status_o.div_last  = (cnt_q == 6'(DIV_STEPS - 1));
    status_o.out_busy  = out_valid_q && out_stall_i;
  end

  logic [61:0]        sq;
  logic [31:0]        sq_t;
  logic [57:0]        lnp;
  logic [22:0]        ln_t;
  logic [29:0]        trial;
  logic [57:0]        mag;
  logic [27:0]        r_abs;
  logic [39:0]        e_sel;
  logic [52:0]        m_sum;
  logic signed [40:0] mean;
  logic [31:0]        pc32, n32;

  always_comb begin
    sq    = 62'(z_q) * 62'(z_q);
    sq_t  = sq[61:30];
    lnp   = 58'({frac_q[19:0]} | (58'(k_q) << 20)) * 58'(LN2_Q32);
    ln_t  = 23'((59'(p_q) + (59'd1 << 35)) >> 36);
    trial = {rem_q, quo_q[57]};
    mag   = num_q[57] ? 58'(-num_q) : 58'(num_q);
    r_abs = ys_q[27] ? 28'(-ys_q) : 28'(ys_q);
    e_sel = only_scale_i ? ce_q : ke_q;
    m_sum = {1'b0, a_q, 4'b0} + 53'((b_q + 48'h8000) >> 16);
    if (ys_q[27]) begin
      mean = (m_sum > (53'd1 << 40)) ? -41'sd1099511627776 : 41'(41'd0 - m_sum[40:0]);
    end else begin
      mean = (m_sum > 53'h0FF_FFFF_FFFF) ? 41'sd1099511627775 : $signed(m_sum[40:0]);
    end
    pc32 = 32'(point_count_i);
    if (pc32 < 32'd2) n32 = 32'd2;
    else if (pc32 > 32'(MaxPoints)) n32 = 32'(MaxPoints);
    else n32 = pc32;
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i)
      CMD_CAPTURE: begin
        op_q  <= in_data_i.opcode;
        e_q   <= (in_data_i.kinetic_energy_kev == 40'd0) ? 40'd1
                                                         : in_data_i.kinetic_energy_kev;
        ke_q  <= in_data_i.kinetic_energy_kev;
        ce_q  <= in_data_i.current_energy_kev;
        k_q   <= 6'd39;
        nm1_q <= AW'(n32 - 32'd1);
      end
      CMD_NORM: begin
        e_q <= {e_q[38:0], 1'b0};
        k_q <= k_q - 6'd1;
      end
      CMD_SQR_INIT: begin
        z_q    <= e_q[39:9];
        frac_q <= '0;
        cnt_q  <= '0;
      end
      CMD_SQR: begin
        z_q    <= sq_t[31] ? sq_t[31:1] : sq_t[30:0];
        frac_q <= {frac_q[18:0], sq_t[31]};
        cnt_q  <= cnt_q + 6'd1;
      end
      CMD_LNMUL: p_q <= lnp;
      CMD_LNFIN: x_q <= $signed({5'b0, ln_t}) - $signed(LN1000_Q16);
      CMD_CAP_LO: begin
        xlo_q <= rd_x;
        ylo_q <= rd_y;
      end
      CMD_CAP_HI: begin
        xhi_q <= rd_x;
        yhi_q <= rd_y;
        j_q   <= AW'(1);
        i_q   <= '0;
      end
      CMD_SRCH_CMP: begin
        if (rd_x <= x_q) i_q <= j_q;
        j_q <= j_q + 1'b1;
      end
      CMD_SEL: begin
        seg_q <= (x_q > xhi_q) ? AW'(nm1_q - 1'b1) : i_q;
        y_q   <= (x_q < xlo_q) ? 60'(ylo_q) : 60'(yhi_q);
      end
      CMD_CAP_S0: begin
        x0_q <= rd_x;
        y0_q <= rd_y;
      end
      CMD_CAP_S1: begin
        x1_q <= rd_x;
        y1_q <= rd_y;
      end
      CMD_DIFF: begin
        dx_q <= 29'(x1_q) - 29'(x0_q);
        dy_q <= 29'(y1_q) - 29'(y0_q);
        xd_q <= 29'(x_q) - 29'(x0_q);
      end
      CMD_Y0:  y_q   <= 60'(y0_q);
      CMD_MUL: num_q <= 58'(dy_q) * 58'(xd_q);
      CMD_DIV_INIT: begin
        neg_q <= num_q[57];
        quo_q <= mag + 58'(dx_q[28:1]);
        rem_q <= '0;
        cnt_q <= '0;
      end
      CMD_DIV: begin
        // restoring divide, one quotient bit a cycle
        if (trial >= {1'b0, dx_q}) begin
          rem_q <= 29'(trial - {1'b0, dx_q});
          quo_q <= {quo_q[56:0], 1'b1};
        end else begin
          rem_q <= trial[28:0];
          quo_q <= {quo_q[56:0], 1'b0};
        end
        cnt_q <= cnt_q + 6'd1;
      end
      CMD_DIV_FIN: y_q <= neg_q ? 60'(y0_q) - $signed({2'b0, quo_q})
                                : 60'(y0_q) + $signed({2'b0, quo_q});
      CMD_SAT: ys_q <= sat28(y_q);
      CMD_SCALE: begin
        a_q <= 48'(r_abs) * 48'(e_sel[39:20]);
        b_q <= 48'(r_abs) * 48'(e_sel[19:0]);
      end
      CMD_FIN: begin
        out_q.mean_energy_kev <= (op_q == OP_SIM) ? mean : 41'sd0;
        out_q.response_value  <= ys_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i == CMD_FIN) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
